// ===== rtl/map_bilinear_interpolator_macros.svh =====
// Assertion macros for the map interpolator. Each macro uses the clock clk
// and the synchronous reset rst of the module that it stands in.
`ifndef MAP_BILINEAR_INTERPOLATOR_MACROS_SVH
`define MAP_BILINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define MBI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("map interpolator check failed");
`define MBI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("map interpolator check failed");
`else
`define MBI_ASSERT_IMP(label, ante, cons)
`define MBI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/mbi_pkg.sv =====
package mbi_pkg;

  localparam int GRID_DIM   = 16;
  localparam int IDX_W      = $clog2(GRID_DIM);
  localparam int CELL_AW    = 2 * IDX_W;
  localparam int CELL_DEPTH = 1 << CELL_AW;
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(GRID_DIM - 1);
  localparam logic [IDX_W-1:0] LAST_M1_IDX = IDX_W'(GRID_DIM - 2);

  // The quotient of one interpolation step never exceeds 255.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_WR_CELL  = 2'd1,
    OP_WR_SPEED = 2'd2,
    OP_WR_LOAD  = 2'd3
  } mbi_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_CHK_LAST,
    S_CHK_FIRST,
    S_SEARCH,
    S_CELL,
    S_LERP_GO,
    S_LERP_WAIT,
    S_FINISH
  } mbi_state_t;

  typedef struct packed {
    logic             cell_we;
    logic             sbp_we;
    logic             lbp_we;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [15:0]      data;
  } mbi_wr_t;

  typedef struct packed {
    logic               axis;
    logic [IDX_W-1:0]   bp_addr;
    logic [CELL_AW-1:0] cell_addr;
  } mbi_rd_t;

endpackage

// ===== rtl/mbi_store.sv =====
module mbi_store (
  input  logic            clk,
  input  mbi_pkg::mbi_wr_t wr,
  input  mbi_pkg::mbi_rd_t rd,
  output logic [15:0]     bp_data,
  output logic [7:0]      cell_data
);

  logic [7:0]  cells [mbi_pkg::CELL_DEPTH];
  logic [15:0] sbp [mbi_pkg::GRID_DIM];
  logic [7:0]  lbp [mbi_pkg::GRID_DIM];
  logic [15:0] sbp_q;
  logic [7:0]  lbp_q;
  logic        axis_q;

  always_ff @(posedge clk) begin
    if (wr.cell_we) begin
      cells[{wr.row, wr.col}] <= wr.data[7:0];
    end
    if (wr.sbp_we) begin
      sbp[wr.row] <= wr.data;
    end
    if (wr.lbp_we) begin
      lbp[wr.col] <= wr.data[7:0];
    end
    sbp_q     <= sbp[rd.bp_addr];
    lbp_q     <= lbp[rd.bp_addr];
    axis_q    <= rd.axis;
    cell_data <= cells[rd.cell_addr];
  end

  assign bp_data = axis_q ? {8'd0, lbp_q} : sbp_q;

endmodule

// ===== rtl/mbi_lerp.sv =====
`include "map_bilinear_interpolator_macros.svh"

module mbi_lerp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  base,
  input  logic [7:0]  other,
  input  logic [15:0] offset,
  input  logic [15:0] gap,
  output logic        done,
  output logic [7:0]  result
);

  logic                          busy;
  logic                          load;
  logic [mbi_pkg::DIV_CNT_W-1:0] cnt;
  logic [23:0]                   prod;
  logic [15:0]                   rem;
  logic [7:0]                    quo;
  logic                          neg;
  logic [7:0]                    base_r;
  logic [15:0]                   gap_r;
  logic [7:0]                    mag;
  logic [16:0]                   trial;
  logic                          ge;
  logic [16:0]                   diff;

  assign mag   = (other > base) ? (other - base) : (base - other);
  assign trial = {rem, quo[7]};
  assign ge    = trial >= {1'b0, gap_r};
  assign diff  = trial - {1'b0, gap_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      load <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        load <= 1'b1;
        cnt  <= '0;
      end else if (busy && load) begin
        load <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mbi_pkg::DIV_CNT_W'(mbi_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Offset never exceeds the gap, so the product stays below 256 times the
  // gap and its upper 16 bits already form a valid partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= 24'(offset) * 24'(mag);
      neg    <= other < base;
      base_r <= base;
      gap_r  <= gap;
    end else if (busy && load) begin
      rem <= prod[23:8];
      quo <= prod[7:0];
    end else if (busy) begin
      rem <= ge ? diff[15:0] : trial[15:0];
      quo <= {quo[6:0], ge};
    end
  end

  assign result = neg ? (base_r - quo) : (base_r + quo);

  `MBI_ASSERT_IMP(a_no_restart, start, !busy)
  `MBI_ASSERT_IMP(a_rem_bound, busy && !load, rem < gap_r)
  `MBI_ASSERT_NXT(a_done_idle, done, !busy && !done)

endmodule

// ===== rtl/map_bilinear_interpolator.sv =====
// Channel  Handshake            Payload
// in       in_valid, in_stall   opcode, row_index, column_index, write_data,
//                               engine_speed, engine_load
// out      out_valid, out_stall map_value, speed_clamped, load_clamped,
//                               was_lookup
// A write item passes through the finish state into the output register. In a
// lookup each axis search reads one breakpoint per cycle, four cells are read,
// and three multiply-divide passes go through one shared unit. The block takes
// one item at a time. A finished result waits in the output register while the
// next item is accepted. Reset clears the sequencer and the output valid; the
// stores hold nothing defined until written.
module map_bilinear_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  row_index,
  input  logic [3:0]  column_index,
  input  logic [15:0] write_data,
  input  logic [15:0] engine_speed,
  input  logic [7:0]  engine_load,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  map_value,
  output logic        speed_clamped,
  output logic        load_clamped,
  output logic        was_lookup
);

  localparam int IW = mbi_pkg::IDX_W;

  mbi_pkg::mbi_state_t state, state_next;
  mbi_pkg::mbi_wr_t    wr;
  mbi_pkg::mbi_rd_t    rd;

  logic          in_acc;
  logic [15:0]   bp_data;
  logic [7:0]    cell_data;
  logic [15:0]   coord;
  logic [7:0]    load_r;
  logic          axis;
  logic          clamp;
  logic [15:0]   prev;
  logic [IW-1:0] idx;
  logic [IW-1:0] s_idx, l_idx;
  logic          s_lerp, l_lerp;
  logic [15:0]   s_gap, l_gap, s_off, l_off;
  logic          s_clamp, l_clamp;
  logic          is_lookup;
  logic [2:0]    cnt;
  logic [7:0]    cell_q [4];
  logic [1:0]    phase;
  logic [7:0]    lo, hi, val;

  logic          ax_done;
  logic [IW-1:0] ax_idx;
  logic          ax_lerp;
  logic          ax_clamp;
  logic [15:0]   ax_gap, ax_off;

  logic          lerp_start, lerp_done;
  logic [7:0]    op_base, op_other, lerp_res;
  logic [15:0]   op_off, op_gap;
  logic          fin_load;

  assign in_stall = state != mbi_pkg::S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign fin_load = (state == mbi_pkg::S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    wr.cell_we = in_acc && (opcode == mbi_pkg::OP_WR_CELL)
                 && (32'(row_index) < mbi_pkg::GRID_DIM)
                 && (32'(column_index) < mbi_pkg::GRID_DIM);
    wr.sbp_we  = in_acc && (opcode == mbi_pkg::OP_WR_SPEED)
                 && (32'(row_index) < mbi_pkg::GRID_DIM);
    wr.lbp_we  = in_acc && (opcode == mbi_pkg::OP_WR_LOAD)
                 && (32'(column_index) < mbi_pkg::GRID_DIM);
    wr.row     = IW'(row_index);
    wr.col     = IW'(column_index);
    wr.data    = write_data;
  end

  always_comb begin
    state_next   = state;
    rd.axis      = axis;
    rd.bp_addr   = mbi_pkg::LAST_IDX;
    rd.cell_addr = {s_idx + IW'(cnt[1]), l_idx + IW'(cnt[0])};
    ax_done      = 1'b0;
    ax_idx       = idx;
    ax_lerp      = 1'b0;
    ax_clamp     = clamp;
    ax_gap       = bp_data - prev;
    ax_off       = coord - prev;
    lerp_start   = 1'b0;
    unique case (state)
      mbi_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = (opcode == mbi_pkg::OP_LOOKUP) ? mbi_pkg::S_RD_LAST
                                                      : mbi_pkg::S_FINISH;
        end
      end
      mbi_pkg::S_RD_LAST: begin
        state_next = mbi_pkg::S_CHK_LAST;
      end
      mbi_pkg::S_CHK_LAST: begin
        rd.bp_addr = '0;
        if (coord > bp_data) begin
          ax_done  = 1'b1;
          ax_idx   = mbi_pkg::LAST_IDX;
          ax_clamp = 1'b1;
        end else begin
          state_next = mbi_pkg::S_CHK_FIRST;
        end
      end
      mbi_pkg::S_CHK_FIRST: begin
        rd.bp_addr = IW'(1);
        state_next = mbi_pkg::S_SEARCH;
      end
      mbi_pkg::S_SEARCH: begin
        rd.bp_addr = idx + IW'(2);
        // A clamp below the first breakpoint leaves coord equal to prev,
        // so the offset on this axis comes out zero.
        if (clamp || (coord >= prev && coord <= bp_data)) begin
          ax_done = 1'b1;
          ax_lerp = bp_data > prev;
        end else if (idx == mbi_pkg::LAST_M1_IDX) begin
          ax_done = 1'b1;
          ax_idx  = mbi_pkg::LAST_IDX;
        end
      end
      mbi_pkg::S_CELL: begin
        if (cnt == 3'd4) begin
          state_next = mbi_pkg::S_LERP_GO;
        end
      end
      mbi_pkg::S_LERP_GO: begin
        lerp_start = 1'b1;
        state_next = mbi_pkg::S_LERP_WAIT;
      end
      mbi_pkg::S_LERP_WAIT: begin
        if (lerp_done) begin
          state_next = (phase == 2'd2) ? mbi_pkg::S_FINISH : mbi_pkg::S_LERP_GO;
        end
      end
      mbi_pkg::S_FINISH: begin
        if (fin_load) begin
          state_next = mbi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mbi_pkg::S_IDLE;
      end
    endcase
    if (ax_done) begin
      state_next = axis ? mbi_pkg::S_CELL : mbi_pkg::S_RD_LAST;
    end
  end

  // Without interpolation on an axis the step runs with a zero offset and
  // the base as its other end, which returns the base unchanged.
  always_comb begin
    case (phase)
      2'd0: begin
        op_base  = cell_q[0];
        op_other = s_lerp ? cell_q[2] : cell_q[0];
        op_off   = s_lerp ? s_off : 16'd0;
        op_gap   = s_lerp ? s_gap : 16'd1;
      end
      2'd1: begin
        op_base  = cell_q[1];
        op_other = s_lerp ? cell_q[3] : cell_q[1];
        op_off   = s_lerp ? s_off : 16'd0;
        op_gap   = s_lerp ? s_gap : 16'd1;
      end
      default: begin
        op_base  = lo;
        op_other = l_lerp ? hi : lo;
        op_off   = l_lerp ? l_off : 16'd0;
        op_gap   = l_lerp ? l_gap : 16'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbi_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord     <= engine_speed;
      load_r    <= engine_load;
      axis      <= 1'b0;
      clamp     <= 1'b0;
      is_lookup <= opcode == mbi_pkg::OP_LOOKUP;
      if (opcode != mbi_pkg::OP_LOOKUP) begin
        val     <= 8'd0;
        s_clamp <= 1'b0;
        l_clamp <= 1'b0;
      end
    end
    if (state == mbi_pkg::S_CHK_FIRST) begin
      prev <= bp_data;
      idx  <= '0;
      if (coord < bp_data) begin
        clamp <= 1'b1;
        coord <= bp_data;
      end
    end
    if (state == mbi_pkg::S_SEARCH && !ax_done) begin
      idx  <= idx + 1'b1;
      prev <= bp_data;
    end
    if (ax_done) begin
      cnt <= '0;
      if (!axis) begin
        s_idx   <= ax_idx;
        s_lerp  <= ax_lerp;
        s_gap   <= ax_gap;
        s_off   <= ax_off;
        s_clamp <= ax_clamp;
        axis    <= 1'b1;
        coord   <= {8'd0, load_r};
        clamp   <= 1'b0;
      end else begin
        l_idx   <= ax_idx;
        l_lerp  <= ax_lerp;
        l_gap   <= ax_gap;
        l_off   <= ax_off;
        l_clamp <= ax_clamp;
      end
    end
    if (state == mbi_pkg::S_CELL) begin
      cnt <= cnt + 3'd1;
      if (cnt != 3'd0) begin
        cell_q[cnt[1:0] - 2'd1] <= cell_data;
      end
      phase <= 2'd0;
    end
    if (state == mbi_pkg::S_LERP_WAIT && lerp_done) begin
      case (phase)
        2'd0:    lo  <= lerp_res;
        2'd1:    hi  <= lerp_res;
        default: val <= lerp_res;
      endcase
      phase <= phase + 2'd1;
    end
    if (fin_load) begin
      map_value     <= val;
      speed_clamped <= s_clamp;
      load_clamped  <= l_clamp;
      was_lookup    <= is_lookup;
    end
  end

  mbi_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .bp_data   (bp_data),
    .cell_data (cell_data)
  );

  mbi_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .base   (op_base),
    .other  (op_other),
    .offset (op_off),
    .gap    (op_gap),
    .done   (lerp_done),
    .result (lerp_res)
  );

endmodule
